>>> rtl/sfr_pkg.sv
// Shared types and constants for the STX/ETX frame receiver.
`timescale 1ns / 1ps

package sfr_pkg;

  localparam int unsigned MAX_PAYLOAD_DEF = 16;

  localparam logic [7:0] BYTE_STX = 8'h02;
  localparam logic [7:0] BYTE_ETX = 8'h03;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UNCHECKED = 2'd1;

  localparam logic [4:0] RESET_MAX_LEN   = 5'd16;
  localparam logic [7:0] RESET_UNCHECKED = 8'hF3;

  typedef enum logic [2:0] {
    ST_HUNT,
    ST_LEN_HI,
    ST_LEN_LO,
    ST_TYPE,
    ST_DATA,
    ST_ETX,
    ST_CHECK,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    KIND_DATA,
    KIND_ACCEPT,
    KIND_REJECT
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE,
    ERR_LEN_HI,
    ERR_TOO_LONG,
    ERR_NO_ETX,
    ERR_CHECKSUM
  } err_t;

  typedef struct packed {
    logic [4:0] max_frame_length;
    logic [7:0] unchecked_type;
  } cfg_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] payload_byte;
    logic [3:0] byte_index;
    logic [7:0] frame_type;
    logic [4:0] frame_length;
    err_t       error_code;
    logic       send_ack;
    logic       last;
  } res_t;

endpackage

>>> rtl/sfr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module sfr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/sfr_ctrl.sv
// Frame parser and payload replay sequencer around the payload RAM.
`timescale 1ns / 1ps

module sfr_ctrl #(
  parameter int unsigned MAX_PAYLOAD = sfr_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic [7:0]                     in_rx_byte,
  output logic                           in_ready,
  input  sfr_pkg::cfg_t                  cfg,
  output logic                           res_valid,
  output sfr_pkg::res_t                  res,
  input  logic                           res_ready,
  output logic                           wr_en,
  output logic [$clog2(MAX_PAYLOAD)-1:0] wr_addr,
  output logic [7:0]                     wr_data,
  output logic                           rd_en,
  output logic [$clog2(MAX_PAYLOAD)-1:0] rd_addr,
  input  logic [7:0]                     rd_data
);

  localparam int unsigned AW = $clog2(MAX_PAYLOAD);

  sfr_pkg::state_t state_r, state_nxt;
  logic [4:0] length_r, length_nxt;
  logic [7:0] type_r, type_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic [7:0] xor_r, xor_nxt;

  logic       acc;
  logic [4:0] limit;
  logic [4:0] n_items;
  logic [4:0] cnt_plus;
  logic       len_hi_bad;
  logic       too_long;
  logic       etx_bad;
  logic       sum_bad;

  assign acc      = in_valid && in_ready;
  assign limit    = (32'(cfg.max_frame_length) < MAX_PAYLOAD) ? cfg.max_frame_length
                                                               : 5'(MAX_PAYLOAD);
  assign n_items  = (length_r == 5'd0) ? 5'd0 : length_r - 5'd1;
  assign cnt_plus = cnt_r + 5'd1;

  assign len_hi_bad = (in_rx_byte != 8'h00);
  assign too_long   = (in_rx_byte > {3'b000, limit});
  assign etx_bad    = (in_rx_byte != sfr_pkg::BYTE_ETX);
  assign sum_bad    = (type_r != cfg.unchecked_type) && (in_rx_byte != xor_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sfr_pkg::ST_HUNT: begin
        if (acc && in_rx_byte == sfr_pkg::BYTE_STX) state_nxt = sfr_pkg::ST_LEN_HI;
      end
      sfr_pkg::ST_LEN_HI: begin
        if (acc) state_nxt = len_hi_bad ? sfr_pkg::ST_HUNT : sfr_pkg::ST_LEN_LO;
      end
      sfr_pkg::ST_LEN_LO: begin
        if (acc) state_nxt = too_long ? sfr_pkg::ST_HUNT : sfr_pkg::ST_TYPE;
      end
      sfr_pkg::ST_TYPE: begin
        if (acc) state_nxt = (n_items != 5'd0) ? sfr_pkg::ST_DATA : sfr_pkg::ST_ETX;
      end
      sfr_pkg::ST_DATA: begin
        if (acc && cnt_plus >= n_items) state_nxt = sfr_pkg::ST_ETX;
      end
      sfr_pkg::ST_ETX: begin
        if (acc) state_nxt = etx_bad ? sfr_pkg::ST_HUNT : sfr_pkg::ST_CHECK;
      end
      sfr_pkg::ST_CHECK: begin
        if (acc) state_nxt = sum_bad ? sfr_pkg::ST_HUNT : sfr_pkg::ST_EMIT;
      end
      sfr_pkg::ST_EMIT: begin
        if (res_ready && cnt_r == n_items) state_nxt = sfr_pkg::ST_HUNT;
      end
      default: state_nxt = sfr_pkg::ST_HUNT;
    endcase
  end

  // Outputs: handshake, result request, RAM ports
  always_comb begin
    in_ready  = (state_r != sfr_pkg::ST_EMIT) && res_ready;
    res_valid = 1'b0;
    res       = '{kind: sfr_pkg::KIND_REJECT, payload_byte: 8'h00, byte_index: 4'h0,
                  frame_type: type_r, frame_length: length_r,
                  error_code: sfr_pkg::ERR_NONE, send_ack: 1'b0, last: 1'b1};
    wr_en     = 1'b0;
    wr_addr   = AW'(cnt_r);
    wr_data   = in_rx_byte;
    rd_en     = 1'b0;
    rd_addr   = '0;
    unique case (state_r)
      sfr_pkg::ST_LEN_HI: begin
        res_valid      = acc && len_hi_bad;
        res.error_code = sfr_pkg::ERR_LEN_HI;
      end
      sfr_pkg::ST_LEN_LO: begin
        res_valid      = acc && too_long;
        res.error_code = sfr_pkg::ERR_TOO_LONG;
      end
      sfr_pkg::ST_DATA: begin
        wr_en = acc && (32'(cnt_r) < MAX_PAYLOAD);
      end
      sfr_pkg::ST_ETX: begin
        res_valid      = acc && etx_bad;
        res.error_code = sfr_pkg::ERR_NO_ETX;
      end
      sfr_pkg::ST_CHECK: begin
        res_valid      = acc && sum_bad;
        res.error_code = sfr_pkg::ERR_CHECKSUM;
        // prefetch the first payload entry for the replay
        rd_en          = acc && !sum_bad;
      end
      sfr_pkg::ST_EMIT: begin
        res_valid = 1'b1;
        if (cnt_r < n_items) begin
          res.kind         = sfr_pkg::KIND_DATA;
          res.payload_byte = rd_data;
          res.byte_index   = cnt_r[3:0];
          res.last         = 1'b0;
          rd_en            = res_ready;
          rd_addr          = AW'(cnt_plus);
        end else begin
          res.kind     = sfr_pkg::KIND_ACCEPT;
          res.send_ack = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Frame fields and running checksum
  always_comb begin
    length_nxt = length_r;
    type_nxt   = type_r;
    cnt_nxt    = cnt_r;
    xor_nxt    = xor_r;
    unique case (state_r)
      sfr_pkg::ST_HUNT: begin
        if (acc && in_rx_byte == sfr_pkg::BYTE_STX) begin
          length_nxt = 5'd0;
          type_nxt   = 8'h00;
          cnt_nxt    = 5'd0;
          xor_nxt    = 8'h00;
        end
      end
      sfr_pkg::ST_LEN_LO: begin
        if (acc && !too_long) begin
          length_nxt = in_rx_byte[4:0];
          xor_nxt    = xor_r ^ in_rx_byte;
        end
      end
      sfr_pkg::ST_TYPE: begin
        if (acc) begin
          type_nxt = in_rx_byte;
          xor_nxt  = xor_r ^ in_rx_byte;
          cnt_nxt  = 5'd0;
        end
      end
      sfr_pkg::ST_DATA: begin
        if (acc) begin
          xor_nxt = xor_r ^ in_rx_byte;
          cnt_nxt = cnt_plus;
        end
      end
      sfr_pkg::ST_ETX: begin
        if (acc && !etx_bad) xor_nxt = xor_r ^ in_rx_byte;
      end
      sfr_pkg::ST_CHECK: begin
        if (acc && !sum_bad) cnt_nxt = 5'd0;
      end
      sfr_pkg::ST_EMIT: begin
        if (res_ready && cnt_r < n_items) cnt_nxt = cnt_plus;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= sfr_pkg::ST_HUNT;
      length_r <= 5'd0;
      type_r   <= 8'h00;
      cnt_r    <= 5'd0;
      xor_r    <= 8'h00;
    end else begin
      state_r  <= state_nxt;
      length_r <= length_nxt;
      type_r   <= type_nxt;
      cnt_r    <= cnt_nxt;
      xor_r    <= xor_nxt;
    end
  end

endmodule

>>> rtl/stx_etx_frame_receiver.sv
// Top level of the STX/ETX framed packet receiver with XOR checksum.
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Payload
// in_       input      in_valid/in_ready  in_rx_byte
// out_      output     out_valid/out_ready kind, payload_byte, byte_index, frame_type,
//                                          frame_length, error_code, send_ack, last
// cfg_      input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// Each received byte takes one cycle while the result register has room.
// After a good frame the parser replays n = length-1 payload bytes from the payload
// RAM, one entry per cycle while the result register has room, then the accept
// result, taking no input. The registered RAM read is hidden by prefetching entry
// 0 on the checksum byte. Reset is synchronous and active low; the payload RAM is
// not cleared. A stalled output holds its result and blocks further input.

module stx_etx_frame_receiver #(
  parameter int unsigned MAX_PAYLOAD = sfr_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_rx_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_kind,
  output logic [7:0]                    out_payload_byte,
  output logic [3:0]                    out_byte_index,
  output logic [7:0]                    out_frame_type,
  output logic [4:0]                    out_frame_length,
  output logic [2:0]                    out_error_code,
  output logic                          out_send_ack,
  output logic                          out_last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data
);

  localparam int unsigned AW = $clog2(MAX_PAYLOAD);

  sfr_pkg::cfg_t cfg_r;
  sfr_pkg::res_t out_r;
  logic          out_valid_r;

  sfr_pkg::res_t res;
  logic          res_valid;
  logic          res_ready;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;

  // Configuration registers: always ready, unknown indexes drop the request.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_frame_length <= sfr_pkg::RESET_MAX_LEN;
      cfg_r.unchecked_type   <= sfr_pkg::RESET_UNCHECKED;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sfr_pkg::REG_MAX_LEN:   cfg_r.max_frame_length <= cfg_data[4:0];
        sfr_pkg::REG_UNCHECKED: cfg_r.unchecked_type   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  sfr_ctrl #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_rx_byte(in_rx_byte),
    .in_ready  (in_ready),
    .cfg       (cfg_r),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  sfr_ram #(
    .WIDTH(8),
    .DEPTH(MAX_PAYLOAD)
  ) u_payload_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // Result register: load when empty or being drained this cycle.
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_r.kind;
  assign out_payload_byte = out_r.payload_byte;
  assign out_byte_index   = out_r.byte_index;
  assign out_frame_type   = out_r.frame_type;
  assign out_frame_length = out_r.frame_length;
  assign out_error_code   = out_r.error_code;
  assign out_send_ack     = out_r.send_ack;
  assign out_last         = out_r.last;

  // A replayed payload byte is always followed at once by the next result.
  a_replay_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ready && out_r.kind == sfr_pkg::KIND_DATA |=> out_valid_r)
    else $error("gap in payload replay");

  // ACK requested exactly on accepted frames.
  a_ack_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.send_ack == (out_r.kind == sfr_pkg::KIND_ACCEPT)))
    else $error("send_ack does not match result kind");

  // Only rejects carry an error code, and only they and accepts end a run.
  a_err_on_reject: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_r.error_code != sfr_pkg::ERR_NONE) ==
                     (out_r.kind == sfr_pkg::KIND_REJECT)) &&
                    (out_r.last == (out_r.kind != sfr_pkg::KIND_DATA)))
    else $error("error code or last flag inconsistent with result kind");

endmodule
